@@ src/lfgf_pkg.sv @@
`default_nettype none

package lfgf_pkg;

  // table geometry
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ENTRY_W    = 64;  // {start, size}

  localparam logic [31:0] DATA_BASE_RST = 32'd200;

  // input item action codes
  localparam logic ACT_SET  = 1'b0;
  localparam logic ACT_FIND = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_DISK_BLOCKS = 1'b0;
  localparam logic REG_DATA_BASE   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NEXT,
    S_CAND,
    S_PREP,
    S_SCAN,
    S_DRAIN,
    S_EVAL
  } state_e;

endpackage

`default_nettype wire

@@ src/lfgf_ram.sv @@
`default_nettype none

module lfgf_ram #(
  parameter  int unsigned WIDTH = 64,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/largest_free_gap_finder_unit.sv @@
// Channel   Handshake              Payload
// -------   ---------------------  ---------------------------------------------------
// command   start / busy           action_i, slot_index_i, region_start_i, region_size_i
// result    valid_o (one cycle)    gap_start_o, gap_length_o
// config    APB psel/penable/...   paddr[2] selects disk_blocks (0x0) or data_base (0x4)
//
// set_entry: its all-zero result shows in the following cycle.
// find: the candidates are the data base and the end of each used slot, an empty
// slot giving none. Each candidate within the disk sweeps the whole region table
// once through its single read port; a candidate past the disk end skips the sweep.
// Reset clears the slot-valid flops at once, so no clearing pass is needed.
// The receiver cannot stall: each result beat lasts exactly one cycle.
`default_nettype none

module largest_free_gap_finder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        action_i,
  input  wire logic [5:0]  slot_index_i,
  input  wire logic [31:0] region_start_i,
  input  wire logic [31:0] region_size_i,
  // result channel
  output logic             valid_o,
  output logic [31:0]      gap_start_o,
  output logic [31:0]      gap_length_o,
  // APB config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import lfgf_pkg::*;

  // ---------------------------------------------------------------------------
  // Config registers. Only paddr[2] decodes the register; low bits are ignored.
  // ---------------------------------------------------------------------------
  logic [31:0] disk_q;
  logic [31:0] base_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= '0;
      base_q <= DATA_BASE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DISK_BLOCKS) begin
        disk_q <= pwdata;
      end else begin
        base_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_DATA_BASE) ? base_q : disk_q;

  // ---------------------------------------------------------------------------
  // Region table: {start, size} per slot in one RAM; used flags in flops so
  // that reset empties every slot at once. Writes only happen while idle and
  // reads only while busy, so the two never touch the same entry together.
  // ---------------------------------------------------------------------------
  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  lfgf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [31:0] rd_start;
  logic [31:0] rd_size;
  assign rd_start = ram_rdata[63:32];
  assign rd_size  = ram_rdata[31:0];

  // ---------------------------------------------------------------------------
  // Control and datapath state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [SLOT_W:0]   cand_q, cand_d;       // slot of current candidate
  logic              base_cand_q, base_cand_d;  // current candidate is data_base
  logic [32:0]       a_q, a_d;             // candidate start, 33 bits for overflow
  logic [31:0]       near_q, near_d;       // nearest distance so far
  logic              found_q, found_d;
  logic [SLOT_W-1:0] scan_q, scan_d;
  logic              rd_vld_q, rd_vld_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [31:0]       best_start_q, best_start_d;
  logic [31:0]       best_len_q, best_len_d;
  logic              valid_q, valid_d;
  logic [31:0]       gs_q, gs_d;
  logic [31:0]       gl_q, gl_d;

  logic              accept;
  logic [31:0]       slot_ext;
  logic [SLOT_W:0]   nxt_cand;
  logic [31:0]       delta;
  logic [31:0]       run_len;

  assign accept   = start & ~busy;
  assign slot_ext = 32'(slot_index_i);
  assign busy     = (state_q != S_IDLE);
  assign nxt_cand = base_cand_q ? '0 : cand_q + (SLOT_W+1)'(1);
  assign delta    = rd_start - a_q[31:0];
  assign run_len  = found_q ? near_q : disk_q - a_q[31:0];

  assign valid_o      = valid_q;
  assign gap_start_o  = gs_q;
  assign gap_length_o = gl_q;

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    cand_d       = cand_q;
    base_cand_d  = base_cand_q;
    a_d          = a_q;
    near_d       = near_q;
    found_d      = found_q;
    scan_d       = scan_q;
    rd_vld_d     = 1'b0;
    rd_slot_d    = rd_slot_q;
    best_start_d = best_start_q;
    best_len_d   = best_len_q;
    valid_d      = 1'b0;
    gs_d         = gs_q;
    gl_d         = gl_q;
    ram_we       = 1'b0;
    ram_waddr    = slot_ext[SLOT_W-1:0];
    ram_wdata    = {region_start_i, region_size_i};
    ram_re       = 1'b0;
    ram_raddr    = scan_q;

    // nearest-start scan: one table entry per cycle, read data registered by the RAM
    if (rd_vld_q && used_q[rd_slot_q] && ({1'b0, rd_start} >= a_q) && (delta < near_q)) begin
      near_d  = delta;
      found_d = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_SET) begin
            if (slot_ext < 32'(SLOTS)) begin
              ram_we                          = 1'b1;
              used_d[slot_ext[SLOT_W-1:0]]    = (region_size_i != '0);
            end
            valid_d = 1'b1;
            gs_d    = '0;
            gl_d    = '0;
          end else begin
            a_d          = {1'b0, base_q};
            base_cand_d  = 1'b1;
            cand_d       = '0;
            best_start_d = base_q;
            best_len_d   = '0;
            state_d      = S_PREP;
          end
        end
      end
      S_NEXT: begin
        base_cand_d = 1'b0;
        cand_d      = nxt_cand;
        if (nxt_cand == (SLOT_W+1)'(SLOTS)) begin
          valid_d = 1'b1;
          gs_d    = best_start_q;
          gl_d    = best_len_q;
          state_d = S_IDLE;
        end else if (used_q[nxt_cand[SLOT_W-1:0]]) begin
          ram_re    = 1'b1;
          ram_raddr = nxt_cand[SLOT_W-1:0];
          state_d   = S_CAND;
        end
      end
      S_CAND: begin
        a_d     = {1'b0, rd_start} + {1'b0, rd_size};
        state_d = S_PREP;
      end
      S_PREP: begin
        if (a_q > {1'b0, disk_q}) begin
          state_d = S_NEXT;  // past the disk end: length zero never wins
        end else begin
          near_d  = disk_q;
          found_d = 1'b0;
          scan_d  = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_q;
        rd_vld_d  = 1'b1;
        rd_slot_d = scan_q;
        scan_d    = scan_q + SLOT_W'(1);
        if (scan_q == SLOT_W'(SLOTS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (run_len > best_len_q) begin
          best_len_d   = run_len;
          best_start_d = a_q[31:0];
        end
        state_d = S_NEXT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      rd_vld_q    <= 1'b0;
      valid_q     <= 1'b0;
      base_cand_q <= 1'b0;
      cand_q      <= '0;
      scan_q      <= '0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      rd_vld_q    <= rd_vld_d;
      valid_q     <= valid_d;
      base_cand_q <= base_cand_d;
      cand_q      <= cand_d;
      scan_q      <= scan_d;
      found_q     <= found_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    near_q       <= near_d;
    rd_slot_q    <= rd_slot_d;
    best_start_q <= best_start_d;
    best_len_q   <= best_len_d;
    gs_q         <= gs_d;
    gl_q         <= gl_d;
  end

endmodule

`default_nettype wire

@@ src/lfgf_checker.sv @@
`default_nettype none

module lfgf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        action_i,
  input wire logic        valid_o,
  input wire logic [31:0] gap_start_o,
  input wire logic [31:0] gap_length_o
);

  import lfgf_pkg::*;

  // set_entry answers with an all-zero beat in the next cycle
  a_set_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACT_SET) |=>
      (valid_o && gap_start_o == '0 && gap_length_o == '0))
    else $error("set_entry beat missing or not zero");

  // find keeps the block busy from the next cycle
  a_find_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACT_FIND) |=> busy)
    else $error("find accepted but block not busy");

  // end of a find always delivers its beat
  a_find_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("find ended without result beat");

  // results only show while idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result beat while busy");

endmodule

bind largest_free_gap_finder_unit lfgf_checker u_lfgf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .action_i     (action_i),
  .valid_o      (valid_o),
  .gap_start_o  (gap_start_o),
  .gap_length_o (gap_length_o)
);

`default_nettype wire

@@ tb/largest_free_gap_finder_unit_tb.sv @@
module largest_free_gap_finder_unit_tb;
  import lfgf_pkg::*;

  // limit covers ~140 command beats, each a worst-case find, several times over
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [31:0] gap_start;
    logic [31:0] gap_length;
  } gap_result_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic        action_i       = ACT_SET;
  logic [5:0]  slot_index_i   = '0;
  logic [31:0] region_start_i = '0;
  logic [31:0] region_size_i  = '0;
  logic        valid_o;
  logic [31:0] gap_start_o;
  logic [31:0] gap_length_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // predictor state: the region table and the two registers
  logic [31:0] tbl_start [SLOTS];
  logic [31:0] tbl_size  [SLOTS];
  logic [31:0] disk_blocks_q;
  logic [31:0] data_base_q;

  gap_result_t gaps_due[$];
  gap_result_t gap_want;
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int          sender_idle_pct = 0;

  largest_free_gap_finder_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .slot_index_i   (slot_index_i),
    .region_start_i (region_start_i),
    .region_size_i  (region_size_i),
    .valid_o        (valid_o),
    .gap_start_o    (gap_start_o),
    .gap_length_o   (gap_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, gaps_due.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // free run from a candidate; the candidate is 33 bits so region ends that wrap
  // past 2^32 land beyond the disk end
  function automatic logic [31:0] free_run_from(input logic [32:0] from);
    logic [32:0] delta;
    logic [31:0] nearest;
    bit          hit;
    if (from > {1'b0, disk_blocks_q})
      return '0;
    nearest = disk_blocks_q;
    hit     = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_size[s] != '0 && {1'b0, tbl_start[s]} >= from) begin
        delta = {1'b0, tbl_start[s]} - from;
        if (delta[31:0] < nearest) begin
          nearest = delta[31:0];
          hit     = 1'b1;
        end
      end
    end
    if (!hit)
      nearest = disk_blocks_q - from[31:0];
    return nearest;
  endfunction

  // applies one command beat to the table and returns the result it must give
  function automatic gap_result_t predict_gap(input logic act, input logic [5:0] slot,
                                              input logic [31:0] rs, input logic [31:0] rsz);
    gap_result_t res;
    logic [32:0] cand;
    logic [31:0] run;
    res = '0;
    if (act == ACT_SET) begin
      if (int'(slot) < SLOTS) begin
        tbl_start[slot] = rs;
        tbl_size[slot]  = rsz;
      end
      return res;
    end
    res.gap_start  = data_base_q;
    res.gap_length = free_run_from({1'b0, data_base_q});
    for (int s = 0; s < SLOTS; s++) begin
      if (tbl_size[s] != '0) begin
        cand = {1'b0, tbl_start[s]} + {1'b0, tbl_size[s]};
        run  = free_run_from(cand);
        // strictly longer only, so the earlier candidate keeps a tie
        if (run > res.gap_length) begin
          res.gap_length = run;
          res.gap_start  = cand[31:0];
        end
      end
    end
    return res;
  endfunction

  // monitor: checks result beats, predicts accepted command beats, tracks writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        if (gaps_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: start %h length %h", gap_start_o, gap_length_o);
        end else begin
          gap_want = gaps_due.pop_front();
          if (gap_start_o !== gap_want.gap_start)
            note_mismatch("gap_start", gap_want.gap_start, gap_start_o);
          if (gap_length_o !== gap_want.gap_length)
            note_mismatch("gap_length", gap_want.gap_length, gap_length_o);
        end
      end
      if (start && !busy)
        gaps_due.push_back(predict_gap(action_i, slot_index_i, region_start_i, region_size_i));
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_DISK_BLOCKS: disk_blocks_q = pwdata;
          REG_DATA_BASE:   data_base_q   = pwdata;
          default: ;
        endcase
      end
    end
  end

  // one command beat, with random idle cycles ahead of it; start is left high
  task automatic send_item(input logic act, input logic [5:0] slot,
                           input logic [31:0] rs, input logic [31:0] rsz);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start          = 1'b0;
      action_i       = 1'($urandom);
      slot_index_i   = 6'($urandom);
      region_start_i = $urandom;
      region_size_i  = $urandom;
      @(negedge clk_i);
    end
    action_i       = act;
    slot_index_i   = slot;
    region_start_i = rs;
    region_size_i  = rsz;
    start          = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
  endtask

  task automatic find_gap();
    send_item(ACT_FIND, 6'($urandom), $urandom, $urandom);
  endtask

  // drop start and hold off until every result is in and the block is idle
  task automatic wait_for_results();
    @(negedge clk_i);
    start = 1'b0;
    while (gaps_due.size() != 0 || busy)
      @(negedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic sel, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {sel, 2'b00};
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    forever begin
      @(posedge clk_i);
      if (pready) break;
    end
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic sel);
    logic [31:0] rd;
    apb_access(1'b0, sel, $urandom, rd);
    if (sel == REG_DISK_BLOCKS) begin
      if (rd !== disk_blocks_q) note_mismatch("disk_blocks read", disk_blocks_q, rd);
    end else begin
      if (rd !== data_base_q) note_mismatch("data_base read", data_base_q, rd);
    end
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] unused;
    apb_access(1'b1, sel, value, unused);
    check_reg(sel);
  endtask

  task automatic test_reset_state();
    check_reg(REG_DISK_BLOCKS);
    check_reg(REG_DATA_BASE);
    // empty disk, base at 200: candidate beyond the end
    find_gap();
    wait_for_results();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DISK_BLOCKS, 32'hFFFF_FFFF);
    write_reg(REG_DATA_BASE, 32'h0);
    find_gap();
    wait_for_results();
    write_reg(REG_DATA_BASE, 32'hFFFF_FFFF);
    find_gap();
    wait_for_results();
    write_reg(REG_DISK_BLOCKS, 32'h0);
    write_reg(REG_DATA_BASE, 32'h0);
    find_gap();
    wait_for_results();
  endtask

  task automatic test_table_gaps();
    write_reg(REG_DISK_BLOCKS, 32'd1000);
    write_reg(REG_DATA_BASE, 32'd200);
    send_item(ACT_SET, 6'd0, 32'd300, 32'd100);
    send_item(ACT_SET, 6'd63, 32'd700, 32'd50);
    find_gap();
    // region running past the disk end
    send_item(ACT_SET, 6'd10, 32'd900, 32'd200);
    find_gap();
    // region ends that wrap past 2^32
    send_item(ACT_SET, 6'd20, 32'hFFFF_FFF0, 32'h20);
    send_item(ACT_SET, 6'd21, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    find_gap();
    wait_for_results();
  endtask

  task automatic test_ties();
    write_reg(REG_DATA_BASE, 32'd0);
    // base run and the run after slot 0 are both 400 long: base keeps it
    send_item(ACT_SET, 6'd0, 32'd400, 32'd200);
    send_item(ACT_SET, 6'd63, 32'd0, 32'd0);
    send_item(ACT_SET, 6'd10, 32'd0, 32'd0);
    // empty slot with a start in range must not cut any run
    send_item(ACT_SET, 6'd20, 32'd500, 32'd0);
    send_item(ACT_SET, 6'd21, 32'd0, 32'd0);
    find_gap();
    // region starting exactly at a candidate gives a zero-length run
    send_item(ACT_SET, 6'd1, 32'd600, 32'd50);
    find_gap();
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int n_items);
    logic [31:0] disk;
    logic [31:0] span;
    logic [31:0] rs;
    logic [31:0] rsz;
    int          pick;
    sender_idle_pct = idle_pct;
    wait_for_results();
    pick = $urandom_range(0, 3);
    disk = (pick == 0) ? $urandom : (pick == 1) ? 32'hFFFF_FFFF : $urandom_range(64, 20000);
    write_reg(REG_DISK_BLOCKS, disk);
    write_reg(REG_DATA_BASE, ($urandom_range(0, 3) == 0) ? $urandom
                                                          : $urandom_range(0, disk / 4));
    span = (disk > 32'd64) ? disk / 8 : 32'd8;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) begin
        // hold off until the block has drained, then move the base
        wait_for_results();
        write_reg(REG_DATA_BASE, $urandom_range(0, disk / 2));
      end else if ($urandom_range(0, 19) == 0) begin
        wait_for_results();
      end
      if ($urandom_range(0, 99) < 30) begin
        find_gap();
      end else begin
        rs   = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, disk);
        pick = $urandom_range(0, 19);
        rsz  = (pick < 3) ? 32'd0 : (pick < 17) ? $urandom_range(1, span) : $urandom;
        send_item(ACT_SET,
                  ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 15))
                                             : 6'($urandom_range(0, 63)),
                  rs, rsz);
      end
    end
    wait_for_results();
  endtask

  initial begin
    for (int s = 0; s < SLOTS; s++) begin
      tbl_start[s] = '0;
      tbl_size[s]  = '0;
    end
    disk_blocks_q = '0;
    data_base_q   = DATA_BASE_RST;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct = 29;
    test_reset_state();
    test_register_extremes();
    test_table_gaps();
    test_ties();
    test_random_traffic(29, 40);
    test_random_traffic(87, 40);
    test_random_traffic(0, 40);

    wait_for_results();
    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && gaps_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ largest_free_gap_finder_unit.f @@
src/lfgf_pkg.sv
src/lfgf_ram.sv
src/largest_free_gap_finder_unit.sv
src/lfgf_checker.sv
tb/largest_free_gap_finder_unit_tb.sv
